// ===== hdl/wmmb_pkg.sv =====
package wmmb_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int SPB_W    = 16;
  localparam int MAXB_W   = 15;
  localparam int INDEX_W  = 14;
  localparam int TOTAL_W  = 40;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Peak reset values and limits
  localparam logic signed [SAMPLE_W-1:0] PEAK_POS_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] PEAK_NEG_MIN = 16'sh8000;
  localparam logic [MAXB_W-1:0]          BUCKET_CAP   = 15'd16384;
  localparam logic [TOTAL_W-1:0]         TOTAL_MAX    = {TOTAL_W{1'b1}};

  // Register reset values
  localparam logic [SPB_W-1:0]  SPB_RESET  = 16'd1024;
  localparam logic [MAXB_W-1:0] MAXB_RESET = 15'd4096;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_SPB  = 1'b0,
    REG_MAXB = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef enum logic {
    KIND_BUCKET  = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  // Configuration handed from register file to core
  typedef struct packed {
    logic [SPB_W-1:0]  samples_per_bucket;
    logic [MAXB_W-1:0] max_buckets;
  } cfg_t;

endpackage

// ===== hdl/wmmb_in_if.sv =====
interface wmmb_in_if;
  import wmmb_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface wmmb_out_if;
  import wmmb_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic                       has_peaks;
  logic signed [SAMPLE_W-1:0] peak_min;
  logic signed [SAMPLE_W-1:0] peak_max;
  logic [INDEX_W-1:0]         bucket_index;
  logic [MAXB_W-1:0]          bucket_total;
  logic [TOTAL_W-1:0]         sample_total;

  modport source (output valid, output kind, output has_peaks, output peak_min,
                  output peak_max, output bucket_index, output bucket_total,
                  output sample_total, input ready);
  modport sink   (input valid, input kind, input has_peaks, input peak_min,
                  input peak_max, input bucket_index, input bucket_total,
                  input sample_total, output ready);
endinterface

// ===== hdl/wmmb_regs.sv =====
module wmmb_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wmmb_pkg::APB_AW-1:0]  paddr,
  input  logic [wmmb_pkg::APB_DW-1:0]  pwdata,
  output logic [wmmb_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output wmmb_pkg::cfg_t               cfg
);
  import wmmb_pkg::*;

  logic [SPB_W-1:0]  spb_r;
  logic [MAXB_W-1:0] maxb_r;
  logic              wr_en;
  reg_idx_t          sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = reg_idx_t'(paddr[2]);

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_r  <= SPB_RESET;
      maxb_r <= MAXB_RESET;
    end else if (wr_en) begin
      case (sel)
        REG_SPB:  spb_r  <= pwdata[SPB_W-1:0];
        REG_MAXB: maxb_r <= pwdata[MAXB_W-1:0];
        default:  ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (sel)
      REG_SPB:  prdata = {{(APB_DW-SPB_W){1'b0}}, spb_r};
      REG_MAXB: prdata = {{(APB_DW-MAXB_W){1'b0}}, maxb_r};
      default:  prdata = '0;
    endcase
  end

  assign cfg.samples_per_bucket = spb_r;
  assign cfg.max_buckets        = maxb_r;

endmodule

// ===== hdl/wmmb_core.sv =====
module wmmb_core (
  input  logic           clk,
  input  logic           rst_n,
  input  wmmb_pkg::cfg_t cfg,
  wmmb_in_if.sink        in_bus,
  wmmb_out_if.source     out_bus
);
  import wmmb_pkg::*;

  // input stage
  logic                       stg_valid_r, stg_valid_nxt;
  logic                       stg_op_r;
  logic signed [SAMPLE_W-1:0] stg_sample_r;

  // bucket state
  logic [SPB_W-1:0]           fill_r, fill_nxt;
  logic signed [SAMPLE_W-1:0] min_r, min_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  logic [MAXB_W-1:0]          done_r, done_nxt;
  logic [TOTAL_W-1:0]         seen_r, seen_nxt;

  // result register
  logic                       res_valid_r, res_valid_nxt;
  logic                       res_kind_r, res_kind_nxt;
  logic                       res_peaks_r, res_peaks_nxt;
  logic signed [SAMPLE_W-1:0] res_min_r, res_min_nxt;
  logic signed [SAMPLE_W-1:0] res_max_r, res_max_nxt;
  logic [INDEX_W-1:0]         res_idx_r, res_idx_nxt;
  logic [MAXB_W-1:0]          res_btot_r, res_btot_nxt;
  logic [TOTAL_W-1:0]         res_stot_r, res_stot_nxt;

  logic                       adv;
  logic                       in_take;
  logic [MAXB_W-1:0]          limit;
  logic                       partial;
  logic [SPB_W:0]             fill_inc;
  logic signed [SAMPLE_W-1:0] new_min, new_max;

  // stage moves on when the result register is free or being drained
  assign adv           = !res_valid_r || out_bus.ready;
  assign in_bus.ready  = !stg_valid_r || adv;
  assign in_take       = in_bus.valid && in_bus.ready;

  assign limit    = (cfg.max_buckets > BUCKET_CAP) ? BUCKET_CAP : cfg.max_buckets;
  assign partial  = (fill_r != '0) && (done_r < limit);
  assign fill_inc = {1'b0, fill_r} + {{SPB_W{1'b0}}, 1'b1};
  assign new_min  = (stg_sample_r < min_r) ? stg_sample_r : min_r;
  assign new_max  = (stg_sample_r > max_r) ? stg_sample_r : max_r;

  // one item per cycle while the result register is free or being drained: state update and result select
  always_comb begin
    stg_valid_nxt = in_bus.ready ? in_bus.valid : stg_valid_r;
    fill_nxt      = fill_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    done_nxt      = done_r;
    seen_nxt      = seen_r;
    res_valid_nxt = adv ? 1'b0 : res_valid_r;
    res_kind_nxt  = res_kind_r;
    res_peaks_nxt = res_peaks_r;
    res_min_nxt   = res_min_r;
    res_max_nxt   = res_max_r;
    res_idx_nxt   = res_idx_r;
    res_btot_nxt  = res_btot_r;
    res_stot_nxt  = res_stot_r;

    if (stg_valid_r && adv) begin
      if (op_t'(stg_op_r) == OP_FINISH) begin
        // summary, state untouched
        res_valid_nxt = 1'b1;
        res_kind_nxt  = KIND_SUMMARY;
        res_peaks_nxt = partial;
        res_min_nxt   = partial ? min_r : '0;
        res_max_nxt   = partial ? max_r : '0;
        res_idx_nxt   = '0;
        res_btot_nxt  = done_r + {{(MAXB_W-1){1'b0}}, partial};
        res_stot_nxt  = seen_r;
      end else begin
        if (seen_r != TOTAL_MAX) begin
          seen_nxt = seen_r + {{(TOTAL_W-1){1'b0}}, 1'b1};
        end
        if (done_r < limit) begin
          if (fill_inc >= {1'b0, cfg.samples_per_bucket}) begin
            // bucket complete
            res_valid_nxt = 1'b1;
            res_kind_nxt  = KIND_BUCKET;
            res_peaks_nxt = 1'b1;
            res_min_nxt   = new_min;
            res_max_nxt   = new_max;
            res_idx_nxt   = done_r[INDEX_W-1:0];
            res_btot_nxt  = '0;
            res_stot_nxt  = '0;
            done_nxt      = done_r + {{(MAXB_W-1){1'b0}}, 1'b1};
            fill_nxt      = '0;
            min_nxt       = PEAK_POS_MAX;
            max_nxt       = PEAK_NEG_MIN;
          end else begin
            fill_nxt = fill_inc[SPB_W-1:0];
            min_nxt  = new_min;
            max_nxt  = new_max;
          end
        end
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
      fill_r      <= '0;
      min_r       <= PEAK_POS_MAX;
      max_r       <= PEAK_NEG_MIN;
      done_r      <= '0;
      seen_r      <= '0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      res_valid_r <= res_valid_nxt;
      fill_r      <= fill_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      done_r      <= done_nxt;
      seen_r      <= seen_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_op_r     <= in_bus.operation;
      stg_sample_r <= in_bus.sample;
    end
    res_kind_r  <= res_kind_nxt;
    res_peaks_r <= res_peaks_nxt;
    res_min_r   <= res_min_nxt;
    res_max_r   <= res_max_nxt;
    res_idx_r   <= res_idx_nxt;
    res_btot_r  <= res_btot_nxt;
    res_stot_r  <= res_stot_nxt;
  end

  assign out_bus.valid        = res_valid_r;
  assign out_bus.kind         = res_kind_r;
  assign out_bus.has_peaks    = res_peaks_r;
  assign out_bus.peak_min     = res_min_r;
  assign out_bus.peak_max     = res_max_r;
  assign out_bus.bucket_index = res_idx_r;
  assign out_bus.bucket_total = res_btot_r;
  assign out_bus.sample_total = res_stot_r;

endmodule

// ===== hdl/waveform_min_max_bucketer_unit.sv =====
// Min/max peak decimator for signed Q1.15 audio. Each sample beat (operation 0)
// is folded into the open bucket; when samples_per_bucket samples have been
// seen, one beat with the bucket's min, max and index comes out (0 acts as 1).
// After max_buckets buckets (capped at 16384) samples are only counted. A
// finish beat (operation 1) returns a summary: the open partial bucket if any,
// the bucket total and a 40-bit saturating sample count; it changes no state.
// Timing: one beat per clock sustained while the output is not stalled; a beat's
// result passes the input stage, then the result register, before it is presented.
// Configuration via APB at 0x0 (samples_per_bucket) and 0x4 (max_buckets);
// write only when idle.
module waveform_min_max_bucketer_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  wmmb_in_if.sink                      in_bus,
  wmmb_out_if.source                   out_bus,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wmmb_pkg::APB_AW-1:0]  paddr,
  input  logic [wmmb_pkg::APB_DW-1:0]  pwdata,
  output logic [wmmb_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import wmmb_pkg::*;

  cfg_t cfg;

  // configuration registers
  wmmb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // bucketing datapath
  wmmb_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

endmodule

// ===== verif/tb_waveform_min_max_bucketer_unit.sv =====
module tb_waveform_min_max_bucketer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import wmmb_pkg::*;

  localparam int LATENCY         = 2;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int N_PHASES        = 12;
  localparam int BEATS_PER_PHASE = 155;
  localparam int N_DIR           = 27;

  typedef enum logic {
    ACT_BEAT = 1'b0,
    ACT_CFG  = 1'b1
  } act_t;

  typedef enum logic [1:0] {
    RX_OPEN    = 2'd0,
    RX_PATTERN = 2'd1,
    RX_RANDOM  = 2'd2
  } rx_mode_t;

  typedef struct packed {
    kind_t                      kind;
    logic                       has_peaks;
    logic signed [SAMPLE_W-1:0] pmin;
    logic signed [SAMPLE_W-1:0] pmax;
    logic [INDEX_W-1:0]         idx;
    logic [MAXB_W-1:0]          btotal;
    logic [TOTAL_W-1:0]         stotal;
  } peak_rec_t;

  typedef struct packed {
    act_t                       act;
    op_t                        op;
    logic signed [SAMPLE_W-1:0] smp;
    reg_idx_t                   ridx;
    logic [APB_DW-1:0]          val;
    logic                       typed;
    peak_rec_t                  rec;
  } dir_row_t;

  logic clk;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  wmmb_in_if  in_chan ();
  wmmb_out_if out_chan ();

  waveform_min_max_bucketer_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_chan.sink),
    .out_bus (out_chan.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of configuration and bucket state
  logic [SPB_W-1:0]           cur_spb;
  logic [MAXB_W-1:0]          cur_maxb;
  logic [SPB_W-1:0]           fill_n;
  logic signed [SAMPLE_W-1:0] low_peak;
  logic signed [SAMPLE_W-1:0] high_peak;
  logic [MAXB_W-1:0]          done_n;
  logic [TOTAL_W-1:0]         seen_n;

  peak_rec_t pending_peaks[$];
  int        err_count   = 0;
  int        burst_left  = 0;
  int        gap_max     = 0;
  int        hold_cycles = 0;
  rx_mode_t  rx_mode     = RX_OPEN;

  // Directed rows; typed results are the ones readable by eye
  dir_row_t dir_rows [N_DIR] = '{
    '{ACT_BEAT, OP_FINISH, 16'sh0000, REG_SPB, 32'd0, 1'b1,
      '{KIND_SUMMARY, 1'b0, 16'sh0000, 16'sh0000, 14'd0, 15'd0, 40'd0}},
    '{ACT_CFG,  OP_SAMPLE, 16'sh0000, REG_SPB, 32'd2, 1'b0, '0},
    '{ACT_BEAT, OP_SAMPLE, 16'sh7FFF, REG_SPB, 32'd0, 1'b0, '0},
    '{ACT_BEAT, OP_SAMPLE, 16'sh8000, REG_SPB, 32'd0, 1'b1,
      '{KIND_BUCKET, 1'b1, 16'sh8000, 16'sh7FFF, 14'd0, 15'd0, 40'd0}},
    '{ACT_BEAT, OP_SAMPLE, 16'sh0000, REG_SPB, 32'd0, 1'b0, '0},
    '{ACT_BEAT, OP_FINISH, 16'shFFFF, REG_SPB, 32'd0, 1'b1,
      '{KIND_SUMMARY, 1'b1, 16'sh0000, 16'sh0000, 14'd0, 15'd2, 40'd3}},
    '{ACT_BEAT, OP_SAMPLE, 16'shFFFF, REG_SPB, 32'd0, 1'b0, '0},
    // zero bucket size acts as one
    '{ACT_CFG,  OP_SAMPLE, 16'sh0000, REG_SPB, 32'd0, 1'b0, '0},
    '{ACT_BEAT, OP_SAMPLE, 16'sh5555, REG_SPB, 32'd0, 1'b0, '0},
    '{ACT_BEAT, OP_SAMPLE, 16'shAAAA, REG_SPB, 32'd0, 1'b0, '0},
    '{ACT_CFG,  OP_SAMPLE, 16'sh0000, REG_SPB, 32'hFFFF_FFFF, 1'b0, '0},
    '{ACT_BEAT, OP_SAMPLE, 16'sh0001, REG_SPB, 32'd0, 1'b0, '0},
    '{ACT_BEAT, OP_SAMPLE, 16'shFFFE, REG_SPB, 32'd0, 1'b0, '0},
    '{ACT_BEAT, OP_FINISH, 16'sh1234, REG_SPB, 32'd0, 1'b0, '0},
    // size lowered under an open bucket
    '{ACT_CFG,  OP_SAMPLE, 16'sh0000, REG_SPB, 32'd3, 1'b0, '0},
    '{ACT_BEAT, OP_SAMPLE, 16'sh0064, REG_SPB, 32'd0, 1'b0, '0},
    // limit zero: samples only counted
    '{ACT_CFG,  OP_SAMPLE, 16'sh0000, REG_MAXB, 32'd0, 1'b0, '0},
    '{ACT_BEAT, OP_SAMPLE, 16'sh0007, REG_SPB, 32'd0, 1'b0, '0},
    '{ACT_BEAT, OP_FINISH, 16'sh0000, REG_SPB, 32'd0, 1'b0, '0},
    '{ACT_CFG,  OP_SAMPLE, 16'sh0000, REG_MAXB, 32'h0000_7FFF, 1'b0, '0},
    '{ACT_CFG,  OP_SAMPLE, 16'sh0000, REG_SPB, 32'd2, 1'b0, '0},
    '{ACT_BEAT, OP_SAMPLE, 16'sh0003, REG_SPB, 32'd0, 1'b0, '0},
    // limit lowered to buckets done with a partial open
    '{ACT_CFG,  OP_SAMPLE, 16'sh0000, REG_MAXB, 32'd5, 1'b0, '0},
    '{ACT_BEAT, OP_FINISH, 16'sh0000, REG_SPB, 32'd0, 1'b0, '0},
    '{ACT_BEAT, OP_SAMPLE, 16'shFFFB, REG_SPB, 32'd0, 1'b0, '0},
    '{ACT_CFG,  OP_SAMPLE, 16'sh0000, REG_MAXB, 32'd16384, 1'b0, '0},
    '{ACT_BEAT, OP_SAMPLE, 16'sh0009, REG_SPB, 32'd0, 1'b0, '0}
  };

  always #1 clk = ~clk;

  // Fold one beat into the predicted state; returns 1 when a result is due
  function automatic bit fold_beat(input op_t op, input logic signed [SAMPLE_W-1:0] smp,
                                   output peak_rec_t rec);
    logic [MAXB_W-1:0] lim;
    logic              part;
    logic [SPB_W:0]    nfill;
    lim = (cur_maxb > BUCKET_CAP) ? BUCKET_CAP : cur_maxb;
    rec = '0;
    if (op == OP_FINISH) begin
      part = (fill_n != '0) && (done_n < lim);
      rec.kind      = KIND_SUMMARY;
      rec.has_peaks = part;
      if (part) begin
        rec.pmin = low_peak;
        rec.pmax = high_peak;
      end
      rec.btotal = done_n + MAXB_W'(part);
      rec.stotal = seen_n;
      return 1'b1;
    end
    if (seen_n != TOTAL_MAX)
      seen_n = seen_n + TOTAL_W'(1);
    if (done_n >= lim)
      return 1'b0;
    if (smp < low_peak)
      low_peak = smp;
    if (smp > high_peak)
      high_peak = smp;
    nfill = {1'b0, fill_n} + (SPB_W+1)'(1);
    if (nfill >= {1'b0, cur_spb}) begin
      rec.kind      = KIND_BUCKET;
      rec.has_peaks = 1'b1;
      rec.pmin      = low_peak;
      rec.pmax      = high_peak;
      rec.idx       = done_n[INDEX_W-1:0];
      done_n        = done_n + MAXB_W'(1);
      fill_n        = '0;
      low_peak      = PEAK_POS_MAX;
      high_peak     = PEAK_NEG_MIN;
      return 1'b1;
    end
    fill_n = nfill[SPB_W-1:0];
    return 1'b0;
  endfunction

  // Offer one beat, bursts separated by random gaps
  task automatic send_beat(input op_t op, input logic signed [SAMPLE_W-1:0] smp,
                           input logic typed, input peak_rec_t typed_rec);
    int        gap;
    peak_rec_t rec;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.sample    <= smp;
    do @(posedge clk); while (!in_chan.ready);
    if (fold_beat(op, smp, rec))
      pending_peaks.insert(pending_peaks.size(), typed ? typed_rec : rec);
  endtask

  // Drop valid, wait out every expected result plus pipeline latency
  task automatic settle();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // APB write, then read back the same register
  task automatic cfg_write(input reg_idx_t ridx, input logic [APB_DW-1:0] val);
    logic [APB_DW-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ridx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (ridx == REG_SPB) begin
      cur_spb = val[SPB_W-1:0];
      want    = APB_DW'(cur_spb);
    end else begin
      cur_maxb = val[MAXB_W-1:0];
      want     = APB_DW'(cur_maxb);
    end
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("readback reg %s: expected %0h, got %0h", ridx.name(), want, prdata);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return PEAK_POS_MAX;
      1:       return PEAK_NEG_MIN;
      2:       return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                             input logic [TOTAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  // Result beats against the oldest expectation
  always @(posedge clk) begin
    peak_rec_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_peaks.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", out_chan.kind);
        err_count++;
      end else begin
        want = pending_peaks.pop_front();
        check_field("kind", TOTAL_W'(want.kind), TOTAL_W'(out_chan.kind));
        check_field("has_peaks", TOTAL_W'(want.has_peaks), TOTAL_W'(out_chan.has_peaks));
        check_field("peak_min", TOTAL_W'(want.pmin), TOTAL_W'(out_chan.peak_min));
        check_field("peak_max", TOTAL_W'(want.pmax), TOTAL_W'(out_chan.peak_max));
        check_field("bucket_index", TOTAL_W'(want.idx), TOTAL_W'(out_chan.bucket_index));
        check_field("bucket_total", TOTAL_W'(want.btotal), TOTAL_W'(out_chan.bucket_total));
        check_field("sample_total", want.stotal, out_chan.sample_total);
      end
    end
  end

  // Receiver: stall pattern per mode, plus long holds on request
  initial begin : receiver
    int cyc;
    cyc = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_cycles > 0) begin
        out_chan.ready <= 1'b0;
        hold_cycles--;
      end else begin
        case (rx_mode)
          RX_OPEN:    out_chan.ready <= 1'b1;
          RX_PATTERN: out_chan.ready <= !((cyc % 5 == 2) || (cyc % 13 >= 10));
          default:    out_chan.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Ends the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [APB_DW-1:0] spb_val;
    logic [APB_DW-1:0] maxb_val;
    clk               = 1'b0;
    rst_n            <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.operation <= OP_SAMPLE;
    in_chan.sample    <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    cur_spb   = SPB_RESET;
    cur_maxb  = MAXB_RESET;
    fill_n    = '0;
    low_peak  = PEAK_POS_MAX;
    high_peak = PEAK_NEG_MIN;
    done_n    = '0;
    seen_n    = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].act == ACT_CFG) begin
        settle();
        cfg_write(dir_rows[i].ridx, dir_rows[i].val);
      end else begin
        send_beat(dir_rows[i].op, dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].rec);
      end
    end

    // Random phases, each with its own settings and idling
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      if (ph == 2)
        spb_val = 0;
      else if (ph == 5)
        spb_val = 65535;
      else if (ph == 7)
        spb_val = 1;
      else if (ph % 4 == 3)
        spb_val = $urandom_range(20, 80);
      else
        spb_val = $urandom_range(2, 12);
      if (ph == 3)
        maxb_val = 0;
      else if (ph == 4)
        maxb_val = 32767;
      else if (ph == 6)
        maxb_val = $urandom_range(16385, 32767);
      else if (ph == 8)
        maxb_val = done_n + $urandom_range(3, 10);
      else if (ph == 9)
        maxb_val = done_n;
      else if (ph % 2 == 0)
        maxb_val = 16384;
      else
        maxb_val = $urandom_range(done_n + 60, 16384);
      cfg_write(REG_SPB, spb_val);
      cfg_write(REG_MAXB, maxb_val);
      rx_mode = rx_mode_t'(ph % 3);
      gap_max = (ph % 4 == 0) ? 0 : $urandom_range(1, 8);
      // back-pressure: receiver holds off while the sender keeps offering
      if (ph == 1) begin
        gap_max     = 0;
        hold_cycles = 400;
      end
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 6)
          send_beat(OP_FINISH, SAMPLE_W'($urandom), 1'b0, '0);
        else
          send_beat(OP_SAMPLE, pick_sample(), 1'b0, '0);
      end
    end

    settle();
    if (pending_peaks.size() != 0) begin
      $error("%0d results never arrived", pending_peaks.size());
      err_count++;
    end
    if (err_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/wmmb_pkg.sv
hdl/wmmb_in_if.sv
hdl/wmmb_regs.sv
hdl/wmmb_core.sv
hdl/waveform_min_max_bucketer_unit.sv
verif/tb_waveform_min_max_bucketer_unit.sv
